@@ src/clock_second_chance_victim_defines.svh @@
// Assertion macros shared by the clock second-chance victim selector.
// Depends on nothing; included by the top level only.
`ifndef CLOCK_SECOND_CHANCE_VICTIM_DEFINES_SVH
`define CLOCK_SECOND_CHANCE_VICTIM_DEFINES_SVH

// Same-cycle implication, disabled while reset is active
`define CSCV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active
`define CSCV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/cscv_pkg.sv @@
// Shared types and constants of the clock second-chance victim selector.
// Depends on nothing; used by cscv_ctrl, cscv_dp and the top level.
package cscv_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int DEFAULT_KEY_BITS = 64;

    localparam int KEY_W   = 64;
    localparam int COUNT_W = 7;

    typedef enum logic [1:0] {
        OP_TRACK   = 2'd0,
        OP_UNTRACK = 2'd1,
        OP_TOUCH   = 2'd2,
        OP_SELECT  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // Memory read address source
    typedef enum logic [1:0] {
        RD_IDX,
        RD_NEXT,
        RD_CURSOR
    } rd_sel_t;

    // Memory write address and data source
    typedef enum logic [1:0] {
        WR_APPEND,
        WR_SET_REF,
        WR_CLR_REF,
        WR_SHIFT
    } wr_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    start;
        logic    idx_inc;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    visit;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    count_inc;
        logic    count_dec;
        logic    victim_load;
        logic    res_load;
        status_t res_status;
        logic    res_victim;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic at_end;
        logic match;
        logic ref_set;
        logic shift_end;
        logic full;
        logic empty;
        logic sweep_done;
    } sts_t;

endpackage

@@ src/cscv_dp.sv @@
// Datapath of the victim selector: key/reference memory, count, cursor, result registers.
// Depends on cscv_pkg; driven by cscv_ctrl through cmd_t and reports through sts_t.
module cscv_dp #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [cscv_pkg::KEY_W-1:0]          key,
    input  cscv_pkg::cmd_t                      cmd,
    output cscv_pkg::sts_t                      sts,
    output logic [1:0]                          status,
    output logic [cscv_pkg::KEY_W-1:0]          victim_key,
    output logic [cscv_pkg::COUNT_W-1:0]        entry_count
);
    import cscv_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int MW    = KEY_BITS + 1;

    // Entry memory: reference bit on top of the key
    logic [MW-1:0] mem [CAPACITY];
    logic [MW-1:0] rdata_reg;

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] victim_reg;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [AW-1:0]       cursor_reg, cursor_next;

    logic [1:0]          status_reg;
    logic [KEY_W-1:0]    victim_out_reg;
    logic [COUNT_W-1:0]  count_out_reg;

    logic [CNT_W-1:0]    idx_plus;
    logic [CNT_W-1:0]    cursor_plus;
    logic [CNT_W-1:0]    count_less;
    logic [AW-1:0]       rd_addr, wr_addr;
    logic [MW-1:0]       wr_data;
    logic [KEY_BITS+KEY_W-1:0]   victim_ext;
    logic [CNT_W+COUNT_W-1:0]    count_ext;

    assign idx_plus    = idx_reg + CNT_W'(1);
    assign cursor_plus = CNT_W'(cursor_reg) + CNT_W'(1);
    assign count_less  = count_reg - CNT_W'(1);

    // Select memory addresses and write data
    always_comb
    begin
        case (cmd.rd_sel)
            RD_IDX:    rd_addr = idx_reg[AW-1:0];
            RD_NEXT:   rd_addr = idx_plus[AW-1:0];
            RD_CURSOR: rd_addr = cursor_reg;
            default:   rd_addr = idx_reg[AW-1:0];
        endcase
        wr_addr = (cmd.wr_sel == WR_APPEND) ? count_reg[AW-1:0] : idx_reg[AW-1:0];
        case (cmd.wr_sel)
            WR_APPEND:  wr_data = {1'b1, key_reg};
            WR_SET_REF: wr_data = {1'b1, rdata_reg[KEY_BITS-1:0]};
            WR_CLR_REF: wr_data = {1'b0, rdata_reg[KEY_BITS-1:0]};
            WR_SHIFT:   wr_data = rdata_reg;
            default:    wr_data = rdata_reg;
        endcase
    end

    // Write and read the entry memory
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Latch the key and the victim
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg <= key[KEY_BITS-1:0];
        end
        if (cmd.victim_load)
        begin
            victim_reg <= rdata_reg[KEY_BITS-1:0];
        end
    end

    // Next values of walk index, visit count, table count and cursor
    always_comb
    begin
        idx_next    = idx_reg;
        n_next      = n_reg;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        if (cmd.start)
        begin
            idx_next = '0;
            n_next   = '0;
        end
        if (cmd.idx_inc)
        begin
            idx_next = idx_plus;
        end
        if (cmd.visit)
        begin
            idx_next    = CNT_W'(cursor_reg);
            n_next      = n_reg + CNT_W'(1);
            cursor_next = (cursor_plus >= count_reg) ? '0 : cursor_plus[AW-1:0];
        end
        if (cmd.count_inc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.count_dec)
        begin
            count_next = count_less;
            if (CNT_W'(cursor_reg) >= count_less)
            begin
                cursor_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            n_reg      <= '0;
            count_reg  <= '0;
            cursor_reg <= '0;
        end
        else
        begin
            idx_reg    <= idx_next;
            n_reg      <= n_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
        end
    end

    // Widen victim and count to the result field widths
    assign victim_ext = {{KEY_W{1'b0}}, victim_reg};
    assign count_ext  = {{COUNT_W{1'b0}}, count_reg};

    // Capture the result transaction
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            status_reg     <= cmd.res_status;
            victim_out_reg <= cmd.res_victim ? victim_ext[KEY_W-1:0] : '0;
            count_out_reg  <= count_ext[COUNT_W-1:0];
        end
    end

    assign status      = status_reg;
    assign victim_key  = victim_out_reg;
    assign entry_count = count_out_reg;

    // Report conditions to the controller
    assign sts.at_end     = (idx_reg == count_reg);
    assign sts.match      = (rdata_reg[KEY_BITS-1:0] == key_reg);
    assign sts.ref_set    = rdata_reg[KEY_BITS];
    assign sts.shift_end  = (idx_plus >= count_reg);
    assign sts.full       = (count_reg == CNT_W'(CAPACITY));
    assign sts.empty      = (count_reg == '0);
    assign sts.sweep_done = (n_reg == count_reg);

endmodule

@@ src/cscv_ctrl.sv @@
// Controller of the victim selector: sequences search, shift and sweep over the memory.
// Depends on cscv_pkg; drives cscv_dp through cmd_t and owns the handshakes.
module cscv_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        opcode,
    output logic              out_valid,
    input  logic              out_ready,
    input  cscv_pkg::sts_t    sts,
    output cscv_pkg::cmd_t    cmd
);
    import cscv_pkg::*;

    typedef enum logic [2:0] {
        IDLE,
        SRCH_RD,
        SRCH_CMP,
        SHIFT_RD,
        SHIFT_WR,
        SEL_RD,
        SEL_CHK,
        FINISH
    } state_t;

    state_t  state_reg, state_next;
    op_t     op_reg, op_next;
    status_t res_reg, res_next;
    logic    hit_reg, hit_next;
    logic    out_valid_reg, out_valid_next;
    logic    accept;

    assign in_ready  = (state_reg == IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;

    // Decode state into datapath commands and next state
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        res_next       = res_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.rd_sel     = RD_IDX;
        cmd.wr_sel     = WR_SHIFT;
        cmd.res_status = res_reg;
        cmd.res_victim = hit_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    cmd.start = 1'b1;
                    op_next   = op_t'(opcode);
                    hit_next  = 1'b0;
                    res_next  = ST_MISS;
                    if (op_t'(opcode) == OP_SELECT)
                    begin
                        state_next = sts.empty ? FINISH : SEL_RD;
                    end
                    else
                    begin
                        state_next = SRCH_RD;
                    end
                end
            end
            SRCH_RD:
            begin
                if (sts.at_end)
                begin
                    // Key absent
                    state_next = FINISH;
                    if (op_reg == OP_TRACK)
                    begin
                        if (sts.full)
                        begin
                            res_next = ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_en     = 1'b1;
                            cmd.wr_sel    = WR_APPEND;
                            cmd.count_inc = 1'b1;
                            res_next      = ST_DONE;
                        end
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX;
                    state_next = SRCH_CMP;
                end
            end
            SRCH_CMP:
            begin
                if (sts.match)
                begin
                    unique case (op_reg)
                        OP_UNTRACK:
                        begin
                            state_next = SHIFT_RD;
                        end
                        OP_TOUCH:
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = WR_SET_REF;
                            res_next   = ST_DONE;
                            state_next = FINISH;
                        end
                        default:
                        begin
                            // Duplicate track
                            state_next = FINISH;
                        end
                    endcase
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = SRCH_RD;
                end
            end
            SHIFT_RD:
            begin
                if (sts.shift_end)
                begin
                    cmd.count_dec = 1'b1;
                    res_next      = ST_DONE;
                    state_next    = FINISH;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_NEXT;
                    state_next = SHIFT_WR;
                end
            end
            SHIFT_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_SHIFT;
                cmd.idx_inc = 1'b1;
                state_next  = SHIFT_RD;
            end
            SEL_RD:
            begin
                if (sts.sweep_done)
                begin
                    // Every visited bit was set
                    state_next = FINISH;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_CURSOR;
                    cmd.visit  = 1'b1;
                    state_next = SEL_CHK;
                end
            end
            SEL_CHK:
            begin
                if (sts.ref_set)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_CLR_REF;
                    state_next = SEL_RD;
                end
                else
                begin
                    cmd.victim_load = 1'b1;
                    hit_next        = 1'b1;
                    res_next        = ST_DONE;
                    state_next      = FINISH;
                end
            end
            FINISH:
            begin
                // Hand the result to the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            op_reg        <= OP_TRACK;
            res_reg       <= ST_MISS;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            res_reg       <= res_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ src/clock_second_chance_victim.sv @@
// Channel   Dir  tdata                                  tuser
// s_axis    in   key[63:0]                              opcode[1:0]
// m_axis    out  victim_key[63:0], entry_count[70:64]   status[1:0]
//
// One transaction at a time; the controller walks the entry memory one entry per step.
// Track, untrack, touch: search reads and compares each entry scanned; untrack then shifts each
// later entry down with a read and a write; select reads and checks each entry visited, up to
// CAPACITY. Also accept, final end check and finish; no end check when select finds a victim.
// A result waiting on m_axis does not stop the next transaction from being accepted.
// Reset clears count, cursor and control; the entry memory needs no clearing.
// Top level of the clock second-chance victim selector.
// Depends on cscv_pkg, cscv_ctrl, cscv_dp and clock_second_chance_victim_defines.svh.
`include "clock_second_chance_victim_defines.svh"

module clock_second_chance_victim #(
    parameter int CAPACITY = cscv_pkg::DEFAULT_CAPACITY,
    parameter int KEY_BITS = cscv_pkg::DEFAULT_KEY_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // key[63:0]
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // victim_key[63:0], entry_count[70:64], zero[71]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import cscv_pkg::*;

    cmd_t               cmd;
    sts_t               sts;
    logic [KEY_W-1:0]   victim_key;
    logic [COUNT_W-1:0] entry_count;

    cscv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .opcode    (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    cscv_dp #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .key         (s_axis_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .status      (m_axis_tuser),
        .victim_key  (victim_key),
        .entry_count (entry_count)
    );

    assign m_axis_tdata = {1'b0, entry_count, victim_key};

    // Memory writes happen only while a transaction is in progress
    `CSCV_ASSERT_NOW(a_no_write_idle, clk, rst_n, s_axis_tready, !cmd.wr_en, "memory write while idle")

    // Append only into a table with room
    `CSCV_ASSERT_NOW(a_no_append_full, clk, rst_n, cmd.count_inc, !sts.full, "append into full table")

    // A loaded result is presented on the next cycle
    `CSCV_ASSERT_NEXT(a_result_shown, clk, rst_n, cmd.res_load, m_axis_tvalid, "result not presented")

    // A victim is reported only with status done
    `CSCV_ASSERT_NOW(a_victim_done, clk, rst_n, cmd.res_load && cmd.res_victim, cmd.res_status == ST_DONE, "victim without done status")

endmodule
